@@ design/gfb_pkg.sv @@
`default_nettype none

package gfb_pkg;

    localparam int DISPLAY_WIDTH_DEF  = 256;
    localparam int DISPLAY_HEIGHT_DEF = 64;
    localparam int GLYPH_SIZE         = 8;

    localparam logic [1:0] CMD_FILL  = 2'd0;
    localparam logic [1:0] CMD_PLOT  = 2'd1;
    localparam logic [1:0] CMD_GLYPH = 2'd2;
    localparam logic [1:0] CMD_READ  = 2'd3;

    typedef struct packed {
        logic load;
        logic fill_wr;
        logic fill_zero;
        logic dx_adv;
        logic pix_rd;
        logic pix_wr;
        logic byte_rd;
    } dp_cmd_t;

    typedef struct packed {
        logic hit;
        logic dx_last;
        logic fill_last;
    } dp_stat_t;

endpackage

`default_nettype wire

@@ design/gfb_ctrl.sv @@
`default_nettype none

module gfb_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [1:0]       command,
    input  wire gfb_pkg::dp_stat_t stat,
    output gfb_pkg::dp_cmd_t      cmd,
    output logic                  busy,
    output logic                  result_valid
);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_FILL   = 3'd2;
    localparam logic [2:0] ST_PIX    = 3'd3;
    localparam logic [2:0] ST_PIX_RD = 3'd4;
    localparam logic [2:0] ST_PIX_WR = 3'd5;
    localparam logic [2:0] ST_RD     = 3'd6;
    localparam logic [2:0] ST_RD_OUT = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       accept;

    assign accept = start && (state_reg == ST_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.load      = accept;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.fill_wr   = 1'b1;
                cmd.fill_zero = 1'b1;
                if (stat.fill_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (command)
                        gfb_pkg::CMD_FILL:  state_next = ST_FILL;
                        gfb_pkg::CMD_PLOT:  state_next = ST_PIX;
                        gfb_pkg::CMD_GLYPH: state_next = ST_PIX;
                        gfb_pkg::CMD_READ:  state_next = ST_RD;
                        default:            state_next = ST_IDLE;
                    endcase
                end
            end
            ST_FILL:
            begin
                cmd.fill_wr = 1'b1;
                if (stat.fill_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_PIX:
            begin
                if (stat.hit)
                begin
                    state_next = ST_PIX_RD;
                end
                else
                begin
                    cmd.dx_adv = 1'b1;
                    if (stat.dx_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_PIX_RD:
            begin
                cmd.pix_rd = 1'b1;
                state_next = ST_PIX_WR;
            end
            ST_PIX_WR:
            begin
                cmd.pix_wr = 1'b1;
                cmd.dx_adv = 1'b1;
                state_next = stat.dx_last ? ST_IDLE : ST_PIX;
            end
            ST_RD:
            begin
                cmd.byte_rd = 1'b1;
                state_next  = ST_RD_OUT;
            end
            ST_RD_OUT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = (state_reg == ST_RD_OUT);

endmodule

`default_nettype wire

@@ design/gfb_datapath.sv @@
`default_nettype none

module gfb_datapath #(
    parameter int DISPLAY_WIDTH  = gfb_pkg::DISPLAY_WIDTH_DEF,
    parameter int DISPLAY_HEIGHT = gfb_pkg::DISPLAY_HEIGHT_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire gfb_pkg::dp_cmd_t  cmd,
    input  wire logic [1:0]        command,
    input  wire logic signed [9:0] pos_x,
    input  wire logic signed [9:0] pos_y,
    input  wire logic [3:0]        gray_level,
    input  wire logic [2:0]        row_index,
    input  wire logic [7:0]        row_bits,
    input  wire logic [12:0]       read_address,
    output gfb_pkg::dp_stat_t      stat,
    output logic [7:0]             read_data
);

    localparam int ROW_BYTES   = (DISPLAY_WIDTH + 1) / 2;
    localparam int STORE_BYTES = ROW_BYTES * DISPLAY_HEIGHT;
    localparam int AW          = $clog2(STORE_BYTES);
    localparam int XW          = $clog2(DISPLAY_WIDTH);
    localparam int YW          = $clog2(DISPLAY_HEIGHT);

    localparam logic [AW-1:0] ROW_BYTES_A  = AW'(ROW_BYTES);
    localparam logic [AW-1:0] FILL_LAST_A  = AW'(STORE_BYTES - 1);
    localparam logic [10:0]   WIDTH_C      = 11'(DISPLAY_WIDTH);
    localparam logic [10:0]   HEIGHT_C     = 11'(DISPLAY_HEIGHT);
    localparam logic [2:0]    DX_LAST      = 3'(gfb_pkg::GLYPH_SIZE - 1);
    localparam logic [31:0]   STORE_BYTES_C = 32'(STORE_BYTES);

    logic [7:0] mem_q [STORE_BYTES];

    logic signed [9:0] x_reg;
    logic signed [9:0] y_reg;
    logic [3:0]        lvl_reg;
    logic [2:0]        row_reg;
    logic [7:0]        bits_reg;
    logic [12:0]       rd_addr_reg;

    logic [2:0]    dx_reg;
    logic [2:0]    dx_next;
    logic [AW-1:0] fill_cnt_reg;
    logic [AW-1:0] fill_cnt_next;

    logic [AW-1:0] pix_addr_reg;
    logic          odd_reg;
    logic [7:0]    rdata_reg;

    logic [10:0]   px;
    logic [10:0]   py;
    logic          in_range;
    logic [AW-1:0] pix_addr;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic          rd_ok;

    assign px = {x_reg[9], x_reg} + {8'd0, dx_reg};
    assign py = {y_reg[9], y_reg} + {8'd0, row_reg};

    assign in_range = !px[10] && (px < WIDTH_C) && !py[10] && (py < HEIGHT_C);
    assign pix_addr = AW'(py[YW-1:0]) * ROW_BYTES_A + AW'(px[XW-1:1]);

    assign stat.hit       = bits_reg[DX_LAST - dx_reg] && in_range;
    assign stat.dx_last   = (dx_reg == DX_LAST);
    assign stat.fill_last = (fill_cnt_reg == FILL_LAST_A);

    assign dx_next       = cmd.dx_adv ? dx_reg + 3'd1 : dx_reg;
    assign fill_cnt_next = !cmd.fill_wr ? fill_cnt_reg :
                           stat.fill_last ? '0 : fill_cnt_reg + AW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dx_reg       <= '0;
            fill_cnt_reg <= '0;
        end
        else
        begin
            dx_reg       <= dx_next;
            fill_cnt_reg <= fill_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg       <= pos_x;
            y_reg       <= pos_y;
            lvl_reg     <= gray_level;
            row_reg     <= (command == gfb_pkg::CMD_GLYPH) ? row_index : 3'd0;
            bits_reg    <= (command == gfb_pkg::CMD_GLYPH) ? row_bits : 8'h80;
            rd_addr_reg <= read_address;
        end
        pix_addr_reg <= pix_addr;
        odd_reg      <= px[0];
    end

    always_comb
    begin
        mem_we    = cmd.fill_wr || cmd.pix_wr;
        mem_waddr = cmd.fill_wr ? fill_cnt_reg : pix_addr_reg;
        if (cmd.fill_wr)
        begin
            mem_wdata = cmd.fill_zero ? 8'h00 : {lvl_reg, lvl_reg};
        end
        else if (odd_reg)
        begin
            mem_wdata = {rdata_reg[7:4], lvl_reg};
        end
        else
        begin
            mem_wdata = {lvl_reg, rdata_reg[3:0]};
        end
        mem_re    = cmd.pix_rd || cmd.byte_rd;
        mem_raddr = cmd.byte_rd ? AW'(rd_addr_reg) : pix_addr_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_q[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem_q[mem_raddr];
        end
    end

    assign rd_ok     = (32'(rd_addr_reg) < STORE_BYTES_C);
    assign read_data = rd_ok ? rdata_reg : 8'h00;

endmodule

`default_nettype wire

@@ design/gray4_framebuffer_glyph_blitter_unit.sv @@
// A read beat reads the store in ST_RD and returns read_data with result_valid in ST_RD_OUT.
// Fill writes all ROW_BYTES*DISPLAY_HEIGHT store bytes (8192 by default), one store write a cycle.
// Plot and glyph row step through every glyph column; each drawn pixel adds a read and a write.
// A new command is taken once busy is low; the receiver cannot stall result_valid.
// Reset: async active low; afterwards the whole store is cleared to zero while busy is high.
`default_nettype none

module gray4_framebuffer_glyph_blitter_unit #(
    parameter int DISPLAY_WIDTH  = gfb_pkg::DISPLAY_WIDTH_DEF,
    parameter int DISPLAY_HEIGHT = gfb_pkg::DISPLAY_HEIGHT_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [1:0]        command,
    input  wire logic signed [9:0] pos_x,
    input  wire logic signed [9:0] pos_y,
    input  wire logic [3:0]        gray_level,
    input  wire logic [2:0]        row_index,
    input  wire logic [7:0]        row_bits,
    input  wire logic [12:0]       read_address,
    output logic                   result_valid,
    output logic [7:0]             read_data
);

    gfb_pkg::dp_cmd_t  dp_cmd;
    gfb_pkg::dp_stat_t dp_stat;

    gfb_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .command      (command),
        .stat         (dp_stat),
        .cmd          (dp_cmd),
        .busy         (busy),
        .result_valid (result_valid)
    );

    gfb_datapath #(
        .DISPLAY_WIDTH  (DISPLAY_WIDTH),
        .DISPLAY_HEIGHT (DISPLAY_HEIGHT)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (dp_cmd),
        .command      (command),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .gray_level   (gray_level),
        .row_index    (row_index),
        .row_bits     (row_bits),
        .read_address (read_address),
        .stat         (dp_stat),
        .read_data    (read_data)
    );

    a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && command == gfb_pkg::CMD_READ) |-> ##2 result_valid)
        else $error("read beat without result");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && command != gfb_pkg::CMD_READ) |=> ##1 !result_valid)
        else $error("result after non-read beat");

    a_single_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe held");

    a_busy_on_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy)
        else $error("result while idle");

endmodule

`default_nettype wire
